// File: sv/assert_macros.svh
// assertion macros used by nearest_repeat_pair_finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define NRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define NRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define NRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/nrp_pkg.sv
// shared constants and types of the nearest repeat pair finder
package nrp_pkg;

  localparam int KEY_BITS_DEF   = 10;
  localparam int INDEX_BITS_DEF = 16;
  localparam int EPOCH_BITS     = 8;
  localparam int WORD_ID_W      = 10;
  localparam int OUT_IDX_W      = 16;

  // table write control from the sequence logic
  typedef struct packed {
    logic wr_en;
    logic start_clear;
  } tbl_ctl_t;

endpackage

// File: sv/nrp_if.sv
// request channel interfaces of the nearest repeat pair finder
interface nrp_in_if;
  logic                           valid;
  logic                           ready;
  logic [nrp_pkg::WORD_ID_W-1:0]  word_id;
  logic                           last_word;

  modport source (output valid, output word_id, output last_word, input ready);
  modport sink   (input valid, input word_id, input last_word, output ready);
endinterface

interface nrp_out_if;
  logic                           valid;
  logic                           ready;
  logic [nrp_pkg::OUT_IDX_W-1:0]  index_first;
  logic [nrp_pkg::OUT_IDX_W-1:0]  index_second;
  logic                           position_overflow;

  modport source (output valid, output index_first, output index_second,
                  output position_overflow, input ready);
  modport sink   (input valid, input index_first, input index_second,
                  input position_overflow, output ready);
endinterface

// File: sv/nrp_table.sv
// per-token table of epoch mark and last position, with clearing pass
module nrp_table #(
  parameter int KEY_BITS = nrp_pkg::KEY_BITS_DEF,
  parameter int ENTRY_W  = nrp_pkg::EPOCH_BITS + nrp_pkg::INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [KEY_BITS-1:0]  rd_addr,
  output logic [ENTRY_W-1:0]   rd_data,
  input  nrp_pkg::tbl_ctl_t    ctl,
  input  logic [KEY_BITS-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0]   wr_data,
  output logic                 busy
);

  localparam int DEPTH = 1 << KEY_BITS;

  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rd_data_r;
  logic                clr_active_r;
  logic                clr_active_nxt;
  logic [KEY_BITS-1:0] clr_cnt_r;
  logic [KEY_BITS-1:0] clr_cnt_nxt;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == {KEY_BITS{1'b1}}) begin
        clr_active_nxt = 1'b0;
      end
    end else if (ctl.start_clear) begin
      clr_active_nxt = 1'b1;
      clr_cnt_nxt    = '0;
    end
  end

  // reset starts a clearing pass so every entry carries epoch zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

// File: sv/nrp_core.sv
// sequence state: position counter, best pair, overflow and epoch
module nrp_core #(
  parameter int KEY_BITS   = nrp_pkg::KEY_BITS_DEF,
  parameter int INDEX_BITS = nrp_pkg::INDEX_BITS_DEF,
  parameter int ENTRY_W    = nrp_pkg::EPOCH_BITS + INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  last,
  input  logic [ENTRY_W-1:0]    rd_data,
  input  logic                  fwd_hit,
  input  logic [INDEX_BITS-1:0] fwd_pos,
  output logic [INDEX_BITS-1:0] cur_pos,
  output logic                  epoch_max,
  output logic [INDEX_BITS-1:0] res_first,
  output logic [INDEX_BITS-1:0] res_second,
  output logic                  res_ovf,
  output nrp_pkg::tbl_ctl_t     tbl_ctl,
  output logic [ENTRY_W-1:0]    wr_data
);

  localparam int EB = nrp_pkg::EPOCH_BITS;
  localparam int DW = INDEX_BITS + 1;

  logic [INDEX_BITS-1:0] pos_cnt_r, pos_cnt_nxt;
  logic [INDEX_BITS-1:0] best_first_r, best_first_nxt;
  logic [INDEX_BITS-1:0] best_second_r, best_second_nxt;
  logic [DW-1:0]         best_dist_r, best_dist_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [EB-1:0]         epoch_r, epoch_nxt;

  logic                  at_top;
  logic                  prev_seen;
  logic [INDEX_BITS-1:0] prev_pos;
  logic [DW-1:0]         pair_gap;
  logic                  take;

  assign at_top    = (pos_cnt_r == {INDEX_BITS{1'b1}});
  assign epoch_max = (epoch_r == {EB{1'b1}});

  // the item ahead wrote this key after our read was issued: use its position
  assign prev_seen = fwd_hit || (rd_data[ENTRY_W-1:INDEX_BITS] == epoch_r);
  assign prev_pos  = fwd_hit ? fwd_pos : rd_data[INDEX_BITS-1:0];
  assign pair_gap  = (pos_cnt_r >= prev_pos)
                   ? ({1'b0, pos_cnt_r} - {1'b0, prev_pos}) : '0;
  assign take      = prev_seen && (pair_gap < best_dist_r);

  assign cur_pos    = pos_cnt_r;
  assign res_first  = take ? prev_pos  : best_first_r;
  assign res_second = take ? pos_cnt_r : best_second_r;
  assign res_ovf    = ovf_r || at_top;

  assign tbl_ctl.wr_en       = fire;
  assign tbl_ctl.start_clear = fire && last && epoch_max;
  assign wr_data             = {epoch_r, pos_cnt_r};

  always_comb begin
    pos_cnt_nxt     = pos_cnt_r;
    best_first_nxt  = best_first_r;
    best_second_nxt = best_second_r;
    best_dist_nxt   = best_dist_r;
    ovf_nxt         = ovf_r;
    epoch_nxt       = epoch_r;
    if (fire) begin
      if (last) begin
        pos_cnt_nxt     = '0;
        best_first_nxt  = '0;
        best_second_nxt = '0;
        best_dist_nxt   = '1;
        ovf_nxt         = 1'b0;
        // epoch zero marks cleared entries, so a wrap skips to one
        epoch_nxt       = epoch_max ? EB'(1) : epoch_r + 1'b1;
      end else begin
        pos_cnt_nxt     = at_top ? pos_cnt_r : pos_cnt_r + 1'b1;
        ovf_nxt         = res_ovf;
        best_first_nxt  = res_first;
        best_second_nxt = res_second;
        if (take) begin
          best_dist_nxt = pair_gap;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r     <= '0;
      best_first_r  <= '0;
      best_second_r <= '0;
      best_dist_r   <= '1;
      ovf_r         <= 1'b0;
      epoch_r       <= EB'(1);
    end else begin
      pos_cnt_r     <= pos_cnt_nxt;
      best_first_r  <= best_first_nxt;
      best_second_r <= best_second_nxt;
      best_dist_r   <= best_dist_nxt;
      ovf_r         <= ovf_nxt;
      epoch_r       <= epoch_nxt;
    end
  end

endmodule

// File: sv/nearest_repeat_pair_finder.sv
// Nearest repeat pair finder: takes one word token per cycle and, on the word
// marked last, returns the positions of the closest pair of equal tokens
// (the first such pair on ties, 0 and 0 if none repeated) and a sticky flag
// for a sequence longer than the position counter. Sustained rate is one word
// per cycle: the per-token table is a single memory read when the word is taken
// and written as the word leaves the s1 register, with the word just ahead
// forwarded around it. The result is registered in the output register once
// the last word leaves the s1 register, and stays until taken; later words
// keep flowing behind it unless the next last word finds it still occupied.
// Sequences are told apart by an 8-bit epoch mark per table entry instead of
// clearing flags, so after reset, and after every 255th sequence, a pass
// clearing all 2^KEY_BITS entries (1024 at the default) holds input ready low.
`include "assert_macros.svh"

module nearest_repeat_pair_finder #(
  parameter int KEY_BITS   = nrp_pkg::KEY_BITS_DEF,
  parameter int INDEX_BITS = nrp_pkg::INDEX_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  nrp_in_if.sink          in_ch,
  nrp_out_if.source       out_ch
);

  localparam int ENTRY_W = nrp_pkg::EPOCH_BITS + INDEX_BITS;
  localparam int OW      = nrp_pkg::OUT_IDX_W;

  logic                  s1_valid_r;
  logic [KEY_BITS-1:0]   s1_key_r;
  logic                  s1_last_r;
  logic                  fwd_hit_r;
  logic [INDEX_BITS-1:0] fwd_pos_r;

  logic                  out_valid_r;
  logic [OW-1:0]         out_first_r;
  logic [OW-1:0]         out_second_r;
  logic                  out_ovf_r;

  logic                  in_acc;
  logic                  in_rdy;
  logic                  out_free;
  logic                  s1_fire;
  logic                  wrap_block;
  logic [KEY_BITS-1:0]   in_key;

  logic [ENTRY_W-1:0]    rd_data;
  logic [ENTRY_W-1:0]    wr_data;
  logic                  tbl_busy;
  nrp_pkg::tbl_ctl_t     tbl_ctl;
  logic [INDEX_BITS-1:0] cur_pos;
  logic                  epoch_max;
  logic [INDEX_BITS-1:0] res_first;
  logic [INDEX_BITS-1:0] res_second;
  logic                  res_ovf;

  assign in_key     = KEY_BITS'(in_ch.word_id);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_fire    = s1_valid_r && (!s1_last_r || out_free);
  // a last word that wraps the epoch must not let a request in behind it
  assign wrap_block = s1_valid_r && s1_last_r && epoch_max;
  assign in_rdy     = !tbl_busy && !wrap_block && (!s1_valid_r || s1_fire);
  assign in_acc     = in_ch.valid && in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_fire && !s1_last_r && (s1_key_r == in_key);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
        fwd_hit_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_key_r  <= in_key;
      s1_last_r <= in_ch.last_word;
      fwd_pos_r <= cur_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_first_r  <= OW'(res_first);
      out_second_r <= OW'(res_second);
      out_ovf_r    <= res_ovf;
    end
  end

  nrp_table #(
    .KEY_BITS (KEY_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_key),
    .rd_data (rd_data),
    .ctl     (tbl_ctl),
    .wr_addr (s1_key_r),
    .wr_data (wr_data),
    .busy    (tbl_busy)
  );

  nrp_core #(
    .KEY_BITS   (KEY_BITS),
    .INDEX_BITS (INDEX_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .last       (s1_last_r),
    .rd_data    (rd_data),
    .fwd_hit    (fwd_hit_r),
    .fwd_pos    (fwd_pos_r),
    .cur_pos    (cur_pos),
    .epoch_max  (epoch_max),
    .res_first  (res_first),
    .res_second (res_second),
    .res_ovf    (res_ovf),
    .tbl_ctl    (tbl_ctl),
    .wr_data    (wr_data)
  );

  assign in_ch.ready              = in_rdy;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.index_first       = out_first_r;
  assign out_ch.index_second      = out_second_r;
  assign out_ch.position_overflow = out_ovf_r;

  `NRP_ASSERT_NXT(a_last_gives_result, clk, rst_n, s1_fire && s1_last_r, out_valid_r)
  `NRP_ASSERT_IMP(a_fwd_needs_item, clk, rst_n, fwd_hit_r, s1_valid_r)
  `NRP_ASSERT_NXT(a_wrap_starts_clear, clk, rst_n, tbl_ctl.start_clear, tbl_busy)
  `NRP_ASSERT_IMP(a_no_request_in_clear, clk, rst_n, tbl_busy, !in_rdy && !s1_valid_r)

endmodule
